FILE: hw/rtl/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg
// Shared types and codes for the flight mode sequencer: modes, jobs, item
// opcodes, event codes and the structs passed between the modules.
// ----------------------------------------------------------------------------
package fms_pkg;

    // Vehicle modes, same order as the event codes 0 to 7
    typedef enum logic [2:0] {
        MODE_PARKED  = 3'd0,
        MODE_STANDBY = 3'd1,
        MODE_TAKEOFF = 3'd2,
        MODE_GUIDED  = 3'd3,
        MODE_LANDING = 3'd4,
        MODE_LOITER  = 3'd5,
        MODE_SQUARE  = 3'd6,
        MODE_RETURN  = 3'd7
    } mode_t;

    // Guidance jobs started on mode entry
    typedef enum logic [2:0] {
        JOB_NONE    = 3'd0,
        JOB_TAKEOFF = 3'd1,
        JOB_LAND    = 3'd2,
        JOB_CIRCLE  = 3'd3,
        JOB_SQUARE  = 3'd4,
        JOB_PATH    = 3'd5
    } job_t;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_STEP    = 2'd0,
        OP_ENABLE  = 2'd1,
        OP_DISABLE = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    // Event codes on event_req
    localparam logic [3:0] EV_PARKED  = 4'd0;
    localparam logic [3:0] EV_STANDBY = 4'd1;
    localparam logic [3:0] EV_TAKEOFF = 4'd2;
    localparam logic [3:0] EV_GUIDED  = 4'd3;
    localparam logic [3:0] EV_LANDING = 4'd4;
    localparam logic [3:0] EV_LOITER  = 4'd5;
    localparam logic [3:0] EV_SQUARE  = 4'd6;
    localparam logic [3:0] EV_RETURN  = 4'd7;

    // One request as captured in the input register
    typedef struct packed {
        op_t        op;
        logic [3:0] event_req;
        logic       autonomous_mode;
        logic       xy_job_enabled;
        logic       z_job_enabled;
        logic       xy_job_done;
        logic       z_job_done;
        logic       path_active;
    } item_t;

    // Sequencer state
    typedef struct packed {
        mode_t mode;
        logic  entry_pending;
        logic  updates_enabled;
    } seq_state_t;

    // One result
    typedef struct packed {
        mode_t mode_now;
        logic  reset_heading_hold;
        logic  reset_horizontal;
        logic  reset_vertical;
        job_t  start_job;
        logic  path_advance;
        logic  path_release;
        logic  disarm_request;
        logic  bad_event;
    } result_t;

endpackage

FILE: hw/rtl/fms_step.sv
// ----------------------------------------------------------------------------
// fms_step
// Combinational transition logic: from the current state and one request,
// form the next state and the result.
// ----------------------------------------------------------------------------
module fms_step
    import fms_pkg::*;
(
    input  seq_state_t state_cur,
    input  item_t      item,
    output seq_state_t state_nxt,
    output result_t    result
);

    mode_t ev_mode;
    logic  go;
    mode_t go_mode;
    logic  is_entry_mode;

    assign ev_mode       = mode_t'(item.event_req[2:0]);
    assign is_entry_mode = (state_cur.mode == MODE_TAKEOFF) || (state_cur.mode == MODE_GUIDED)
                        || (state_cur.mode == MODE_LANDING) || (state_cur.mode == MODE_LOITER)
                        || (state_cur.mode == MODE_SQUARE);

    always_comb
    begin
        state_nxt = state_cur;
        result    = '0;
        go        = 1'b0;
        go_mode   = state_cur.mode;

        case (item.op)
            OP_ENABLE:
            begin
                // Enable updates and arm the entry job
                if (!state_cur.updates_enabled)
                begin
                    state_nxt.updates_enabled = 1'b1;
                    state_nxt.entry_pending   = 1'b1;
                end
            end
            OP_DISABLE:
            begin
                if (state_cur.updates_enabled)
                begin
                    state_nxt.updates_enabled = 1'b0;
                    state_nxt.entry_pending   = 1'b0;
                end
            end
            OP_STEP:
            begin
                if (state_cur.updates_enabled)
                begin
                    // Consume the pending mark: reset both axes, start the job
                    if (state_cur.entry_pending && is_entry_mode)
                    begin
                        state_nxt.entry_pending = 1'b0;
                        result.reset_horizontal = 1'b1;
                        result.reset_vertical   = 1'b1;
                        case (state_cur.mode)
                            MODE_TAKEOFF: result.start_job = JOB_TAKEOFF;
                            MODE_GUIDED:  result.start_job = JOB_PATH;
                            MODE_LANDING: result.start_job = JOB_LAND;
                            MODE_LOITER:  result.start_job = JOB_CIRCLE;
                            default:      result.start_job = JOB_SQUARE;
                        endcase
                    end

                    // Per-mode event handling
                    case (state_cur.mode)
                        MODE_PARKED:
                        begin
                            if (item.event_req == EV_PARKED)
                            begin
                                result.reset_heading_hold = item.autonomous_mode;
                                result.reset_horizontal   = item.xy_job_enabled;
                                result.reset_vertical     = item.z_job_enabled;
                            end
                            else if (item.event_req == EV_TAKEOFF
                                     || item.event_req == EV_GUIDED)
                            begin
                                go      = 1'b1;
                                go_mode = ev_mode;
                            end
                            else if (item.event_req != EV_LANDING)
                            begin
                                result.bad_event = 1'b1;
                            end
                        end
                        MODE_STANDBY:
                        begin
                            if (item.event_req == EV_STANDBY)
                            begin
                                result.reset_horizontal = item.xy_job_enabled;
                                result.reset_vertical   = item.z_job_enabled;
                            end
                            else if (item.event_req >= EV_TAKEOFF
                                     && item.event_req <= EV_RETURN)
                            begin
                                go      = 1'b1;
                                go_mode = ev_mode;
                            end
                            else
                            begin
                                result.bad_event = 1'b1;
                            end
                        end
                        MODE_TAKEOFF:
                        begin
                            if (item.event_req == EV_TAKEOFF)
                            begin
                                if (item.z_job_done && item.z_job_enabled)
                                    result.reset_vertical = 1'b1;
                            end
                            else if (item.event_req >= EV_STANDBY
                                     && item.event_req <= EV_RETURN)
                            begin
                                go      = 1'b1;
                                go_mode = ev_mode;
                            end
                            else
                            begin
                                result.bad_event = 1'b1;
                            end
                        end
                        MODE_GUIDED:
                        begin
                            if (item.event_req == EV_GUIDED)
                            begin
                                result.path_advance = item.path_active;
                            end
                            else if (item.event_req == EV_STANDBY
                                     || (item.event_req >= EV_LANDING
                                         && item.event_req <= EV_RETURN))
                            begin
                                go                  = 1'b1;
                                go_mode             = ev_mode;
                                result.path_release = 1'b1;
                            end
                            else
                            begin
                                result.bad_event = 1'b1;
                            end
                        end
                        MODE_LANDING:
                        begin
                            if (item.event_req == EV_STANDBY
                                || item.event_req == EV_TAKEOFF)
                            begin
                                go      = 1'b1;
                                go_mode = ev_mode;
                            end
                            else if (item.event_req == EV_LANDING)
                            begin
                                // Touchdown: drop to parked and ask for disarm
                                if (item.z_job_done)
                                begin
                                    if (item.z_job_enabled)
                                        result.reset_vertical = 1'b1;
                                    go                    = 1'b1;
                                    go_mode               = MODE_PARKED;
                                    result.disarm_request = 1'b1;
                                end
                            end
                            else
                            begin
                                result.bad_event = 1'b1;
                            end
                        end
                        MODE_LOITER, MODE_SQUARE:
                        begin
                            if (item.event_req == EV_STANDBY
                                || item.event_req == EV_LANDING)
                            begin
                                go      = 1'b1;
                                go_mode = ev_mode;
                            end
                            else if (item.event_req == {1'b0, state_cur.mode})
                            begin
                                if (item.xy_job_done && item.xy_job_enabled)
                                    result.reset_horizontal = 1'b1;
                            end
                            else
                            begin
                                result.bad_event = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Return falls back to standby on any event
                            go      = 1'b1;
                            go_mode = MODE_STANDBY;
                        end
                    endcase

                    // Apply the mode change
                    if (go)
                    begin
                        state_nxt.mode          = go_mode;
                        state_nxt.entry_pending = 1'b1;
                    end
                end
            end
            default:
            begin
                // Unused opcode: ignore
            end
        endcase

        result.mode_now = state_nxt.mode;
    end

endmodule

FILE: hw/rtl/flight_mode_sequencer.sv
// ----------------------------------------------------------------------------
// flight_mode_sequencer
// Eight-mode vehicle sequencer. Takes enable, disable and step requests and
// returns one result per request with the new mode and command flags.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  -------   -------------------   --------------------------------------------
//  request   cmd_valid/cmd_stall   op, event_req, job and path status bits
//  result    res_valid/res_stall   mode_now, reset/start/path/disarm/bad flags
//
//  One request per cycle while res_stall is low; a request passes through
//  the input register, then the transition logic into the result register.
//  State advances when a request moves from the input register to the
//  result register. Reset clears mode to parked and both flags.
//  A stalled result holds the result register; cmd_stall rises only when
//  the input register is full and cannot move forward.
// ----------------------------------------------------------------------------
module flight_mode_sequencer
    import fms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] op,
    input  logic [3:0] event_req,
    input  logic       autonomous_mode,
    input  logic       xy_job_enabled,
    input  logic       z_job_enabled,
    input  logic       xy_job_done,
    input  logic       z_job_done,
    input  logic       path_active,

    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] mode_now,
    output logic       reset_heading_hold,
    output logic       reset_horizontal,
    output logic       reset_vertical,
    output logic [2:0] start_job,
    output logic       path_advance,
    output logic       path_release,
    output logic       disarm_request,
    output logic       bad_event
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       res_valid_reg;
    result_t    res_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_next;
    logic       advance;
    logic       cmd_take;

    // Move the held request forward when the result register is free
    assign advance   = in_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_item_reg.op              <= op_t'(op);
            in_item_reg.event_req       <= event_req;
            in_item_reg.autonomous_mode <= autonomous_mode;
            in_item_reg.xy_job_enabled  <= xy_job_enabled;
            in_item_reg.z_job_enabled   <= z_job_enabled;
            in_item_reg.xy_job_done     <= xy_job_done;
            in_item_reg.z_job_done      <= z_job_done;
            in_item_reg.path_active     <= path_active;
        end
    end

    // Transition logic
    fms_step u_step (
        .state_cur (state_reg),
        .item      (in_item_reg),
        .state_nxt (state_next),
        .result    (res_next)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode            <= MODE_PARKED;
            state_reg.entry_pending   <= 1'b0;
            state_reg.updates_enabled <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    // Drive result ports
    assign res_valid          = res_valid_reg;
    assign mode_now           = res_reg.mode_now;
    assign reset_heading_hold = res_reg.reset_heading_hold;
    assign reset_horizontal   = res_reg.reset_horizontal;
    assign reset_vertical     = res_reg.reset_vertical;
    assign start_job          = res_reg.start_job;
    assign path_advance       = res_reg.path_advance;
    assign path_release       = res_reg.path_release;
    assign disarm_request     = res_reg.disarm_request;
    assign bad_event          = res_reg.bad_event;

    // A disarm request always lands in parked
    a_disarm_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && disarm_request) |-> (mode_now == MODE_PARKED))
        else $error("disarm request outside parked");

    // A started job always comes with reset of both axes
    a_job_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && start_job != JOB_NONE) |-> (reset_horizontal && reset_vertical))
        else $error("job started without axis reset");

    // Releasing the path means guided was left
    a_release_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && path_release) |-> (mode_now != MODE_GUIDED))
        else $error("path released while staying in guided");

    // While updates are off, the mode cannot change
    a_frozen_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !state_reg.updates_enabled) |=> $stable(state_reg.mode))
        else $error("mode changed while updates disabled");

endmodule
